@@ design/steim_frame_difference_decoder_macros.svh @@
// Assertion shorthands shared by the decoder RTL.
// Each expects clk and rst_n to be visible where it is used.
`ifndef STEIM_FRAME_DIFFERENCE_DECODER_MACROS_SVH
`define STEIM_FRAME_DIFFERENCE_DECODER_MACROS_SVH

// Same-cycle implication.
`define SFDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sfdd_pkg.sv @@
package sfdd_pkg;

    localparam int FRAME_WORDS = 16;
    localparam int POS_W       = $clog2(FRAME_WORDS);

    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
    localparam logic [POS_W-1:0] POS_START  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_FINAL  = POS_W'(FRAME_WORDS - 1);

    // Header bit offset of the code for data word p is 36 - 2*p.
    localparam logic [5:0] CODE_SHIFT_BASE = 6'd36;

    typedef enum logic [1:0] {
        CODE_RAW    = 2'd0,
        CODE_DIFF8  = 2'd1,
        CODE_DIFF16 = 2'd2,
        CODE_DIFF30 = 2'd3
    } code_t;

endpackage

@@ design/sfdd_if.sv @@
interface sfdd_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_word;
    logic        record_start;

    modport source (output valid, output code_word, output record_start, input ready);
    modport sink   (input valid, input code_word, input record_start, output ready);
endinterface

interface sfdd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               record_end;
    logic               run_end;

    modport source (output valid, output sample, output record_end, output run_end,
                    input ready);
    modport sink   (input valid, input sample, input record_end, input run_end,
                    output ready);
endinterface

interface sfdd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/steim_frame_difference_decoder.sv @@
// Frame difference decoder: takes one 32-bit word of a compressed record per
// item and turns data words into 32-bit samples. Frames are 16 words: a header
// of sixteen 2-bit codes, the start value, the last value (ignored) and
// thirteen data words holding a raw sample, four 8-bit, two 16-bit or one
// 30-bit difference. Differences accumulate with a 32-bit wrap from the start
// value. After cfg sets the sample total, output stops once that many samples
// are out; the final sample carries record_end, and the last sample of each
// word carries run_end. A word flagged record_start restarts the record.
// Timing: a word stays in the decode register until it has handed its 1, 2
// or 4 samples, or none, to the single result register, which moves one
// sample per cycle while the receiver keeps ready high. The next word is
// taken in the cycle its predecessor finishes, and a stalled result only
// holds the stage behind it. A word passes the decode register and then
// the result register. Write cfg only while no word is in flight.
`include "steim_frame_difference_decoder_macros.svh"

module steim_frame_difference_decoder
    import sfdd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sfdd_word_if.sink           words,
    sfdd_sample_if.source       samples,
    sfdd_cfg_if.sink            cfg
);

    // Frame tracking and configuration
    logic [POS_W-1:0] pos_reg;
    logic [31:0]      header_reg;
    logic [31:0]      start_reg;
    logic [15:0]      total_reg;

    // Record accumulation
    logic [15:0]      emitted_reg, emitted_next;
    logic [31:0]      prior_reg;

    // Decode register: the word being expanded
    logic             run_valid_reg;
    logic [31:0]      run_word_reg;
    code_t            run_code_reg;
    logic [2:0]       run_cnt_reg;
    logic [1:0]       run_idx_reg;

    // Result register
    logic             out_valid_reg;
    logic [31:0]      out_sample_reg;
    logic             out_rec_end_reg;
    logic             out_run_end_reg;

    logic             words_fire;
    logic [POS_W-1:0] eff_pos;
    logic [POS_W-1:0] pos_next;
    logic [5:0]       code_shift;
    code_t            in_code;
    logic [2:0]       in_cnt;

    logic             slot_free;
    logic             step;
    logic             has_room;
    logic             emit;
    logic             rec_end;
    logic             last_idx;
    logic             run_done;
    logic [31:0]      base;
    logic [31:0]      calc_sample;

    assign cfg.ready = 1'b1;

    // ---------------------------------------------------------------
    // Input side: classify the word by its frame position
    // ---------------------------------------------------------------
    assign words_fire = words.valid && words.ready;
    assign eff_pos    = words.record_start ? POS_HEADER : pos_reg;
    assign pos_next   = (eff_pos == POS_FINAL) ? POS_HEADER : eff_pos + POS_W'(1);
    assign code_shift = CODE_SHIFT_BASE - 6'({eff_pos, 1'b0});

    always_comb
    begin
        in_code = code_t'(2'(header_reg >> code_shift));
        if (eff_pos == POS_HEADER || eff_pos == POS_START || eff_pos == POS_LAST)
        begin
            in_cnt = 3'd0;
        end
        else
        begin
            case (in_code)
                CODE_RAW:    in_cnt = 3'd1;
                CODE_DIFF8:  in_cnt = 3'd4;
                CODE_DIFF16: in_cnt = 3'd2;
                CODE_DIFF30: in_cnt = 3'd1;
                default:     in_cnt = 3'd1;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Expansion: one sample per cycle while the result slot is free
    // ---------------------------------------------------------------
    assign slot_free = !out_valid_reg || samples.ready;
    assign step      = run_valid_reg && slot_free;
    assign has_room  = emitted_reg < total_reg;
    assign emit      = step && (run_cnt_reg != 3'd0) && has_room;
    assign rec_end   = (emitted_reg + 16'd1) == total_reg;
    assign last_idx  = ({1'b0, run_idx_reg} == (run_cnt_reg - 3'd1));
    // Done when the word is exhausted or the record fills up mid-word.
    assign run_done  = step && ((run_cnt_reg == 3'd0) || !has_room || last_idx || rec_end);
    assign base      = (emitted_reg != 16'd0) ? prior_reg : start_reg;

    assign words.ready = !run_valid_reg || run_done;

    sfdd_sample_calc u_calc (
        .word   (run_word_reg),
        .code   (run_code_reg),
        .idx    (run_idx_reg),
        .base   (base),
        .sample (calc_sample)
    );

    // A new record clears the count; this wins over the last sample of the
    // word that finishes in the same cycle.
    always_comb
    begin
        emitted_next = emitted_reg;
        if (emit)
        begin
            emitted_next = emitted_reg + 16'd1;
        end
        if (words_fire && words.record_start)
        begin
            emitted_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HEADER;
            header_reg    <= '0;
            start_reg     <= '0;
            total_reg     <= 16'd1;
            emitted_reg   <= '0;
            prior_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                total_reg <= cfg.data;
            end

            emitted_reg <= emitted_next;
            if (emit)
            begin
                prior_reg <= calc_sample;
            end

            // Advance within the word, or retire it and take the next one.
            if (step && !run_done)
            begin
                run_idx_reg <= run_idx_reg + 2'd1;
            end

            if (words_fire)
            begin
                pos_reg       <= pos_next;
                run_valid_reg <= 1'b1;
                run_idx_reg   <= '0;
                if (eff_pos == POS_HEADER)
                begin
                    header_reg <= words.code_word;
                end
                if (eff_pos == POS_START)
                begin
                    start_reg <= words.code_word;
                end
            end
            else if (run_done)
            begin
                run_valid_reg <= 1'b0;
            end

            // Result register: load on emit, drop once taken.
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (samples.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers hold their value without reset.
    always_ff @(posedge clk)
    begin
        if (words_fire)
        begin
            run_word_reg <= words.code_word;
            run_code_reg <= in_code;
            run_cnt_reg  <= in_cnt;
        end
        if (emit)
        begin
            out_sample_reg  <= calc_sample;
            out_rec_end_reg <= rec_end;
            out_run_end_reg <= last_idx || rec_end;
        end
    end

    assign samples.valid      = out_valid_reg;
    assign samples.sample     = $signed(out_sample_reg);
    assign samples.record_end = out_rec_end_reg;
    assign samples.run_end    = out_run_end_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SFDD_ASSERT_IMP(a_rec_end_ends_run,
        out_valid_reg && out_rec_end_reg, out_run_end_reg,
        "record_end without run_end")

    `SFDD_ASSERT_IMP(a_idx_in_range,
        run_valid_reg && (run_cnt_reg != 3'd0), ({1'b0, run_idx_reg} < run_cnt_reg),
        "sample index past end of word")

    `SFDD_ASSERT_NEXT(a_count_advances,
        emit && !(words_fire && words.record_start),
        emitted_reg == $past(emitted_reg) + 16'd1,
        "sample count did not advance on emit")

    `SFDD_ASSERT_NEXT(a_total_reached,
        emit && rec_end && !(words_fire && words.record_start),
        emitted_reg == total_reg,
        "record_end sample did not reach the total")

endmodule

@@ design/sfdd_sample_calc.sv @@
module sfdd_sample_calc
    import sfdd_pkg::*;
(
    input  logic [31:0] word,
    input  code_t       code,
    input  logic [1:0]  idx,
    input  logic [31:0] base,
    output logic [31:0] sample
);

    logic [7:0]  diff8;
    logic [15:0] diff16;
    logic [31:0] diff;

    always_comb
    begin
        // Most significant piece first: idx 0 takes the top byte or half.
        diff8  = 8'(word >> {~idx, 3'b000});
        diff16 = 16'(word >> {~idx[0], 4'b0000});
        diff   = '0;
        sample = word;
        case (code)
            CODE_RAW:
            begin
                sample = word;
            end
            CODE_DIFF8:
            begin
                diff   = {{24{diff8[7]}}, diff8};
                sample = base + diff;
            end
            CODE_DIFF16:
            begin
                diff   = {{16{diff16[15]}}, diff16};
                sample = base + diff;
            end
            CODE_DIFF30:
            begin
                diff   = {{2{word[29]}}, word[29:0]};
                sample = base + diff;
            end
            default:
            begin
                sample = word;
            end
        endcase
    end

endmodule

@@ test/sfdd_sample_checker.sv @@
module sfdd_sample_checker
    import sfdd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sfdd_word_if   words,
    sfdd_sample_if samples,
    sfdd_cfg_if    cfg,
    output int     mismatch_count,
    output int     samples_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [31:0] sample;
        logic        record_end;
        logic        run_end;
    } sample_rec_t;

    sample_rec_t due_q[$];

    // Shadow of the decoder state
    logic [POS_W-1:0] frame_pos;
    logic [31:0]      hdr_codes;
    logic [31:0]      first_value;
    logic [31:0]      prev_sample;
    logic [15:0]      emitted;
    logic [15:0]      sample_total;

    task automatic report_miss(input string what, input sample_rec_t want,
                               input sample_rec_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s: expected sample %h record_end %b run_end %b, got %h %b %b",
                     $time, what, want.sample, want.record_end, want.run_end,
                     got.sample, got.record_end, got.run_end);
    endtask

    // Decode one accepted word and queue the samples it should yield.
    task automatic decode_word(input logic [31:0] w, input logic restart);
        logic [POS_W-1:0] cur;
        logic [31:0]      diffs [4];
        logic [31:0]      s;
        code_t            code;
        int               nvals;
        int               made;
        if (restart)
        begin
            frame_pos = POS_HEADER;
            emitted   = '0;
        end
        cur       = frame_pos;
        frame_pos = (cur == POS_FINAL) ? POS_HEADER : cur + 1'b1;
        nvals     = 0;
        made      = 0;
        case (cur)
            POS_HEADER: hdr_codes = w;
            POS_START:  first_value = w;
            POS_LAST:   ;
            default:
            begin
                code = code_t'(hdr_codes[int'(CODE_SHIFT_BASE) - 2 * int'(cur) +: 2]);
                case (code)
                    CODE_RAW:
                    begin
                        diffs[0] = w;
                        nvals    = 1;
                    end
                    CODE_DIFF8:
                    begin
                        for (int j = 0; j < 4; j++)
                            diffs[j] = {{24{w[31 - 8 * j]}}, w[31 - 8 * j -: 8]};
                        nvals = 4;
                    end
                    CODE_DIFF16:
                    begin
                        diffs[0] = {{16{w[31]}}, w[31:16]};
                        diffs[1] = {{16{w[15]}}, w[15:0]};
                        nvals    = 2;
                    end
                    default:
                    begin
                        diffs[0] = {{2{w[29]}}, w[29:0]};
                        nvals    = 1;
                    end
                endcase
                for (int k = 0; k < nvals && emitted < sample_total; k++)
                begin
                    if (code == CODE_RAW)
                        s = diffs[k];
                    else
                        s = ((emitted != 0) ? prev_sample : first_value) + diffs[k];
                    prev_sample = s;
                    emitted     = emitted + 1'b1;
                    due_q.push_back('{sample: s, record_end: (emitted == sample_total),
                                      run_end: 1'b0});
                    made++;
                end
                if (made > 0)
                    due_q[due_q.size() - 1].run_end = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_rec_t got;
        sample_rec_t want;
        if (!rst_n)
        begin
            frame_pos      = POS_HEADER;
            hdr_codes      = '0;
            first_value    = '0;
            prev_sample    = '0;
            emitted        = '0;
            sample_total   = 16'd1;
            mismatch_count = 0;
            due_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                sample_total = cfg.data;
            if (words.valid && words.ready)
                decode_word(words.code_word, words.record_start);
            if (samples.valid && samples.ready)
            begin
                got = '{sample: samples.sample, record_end: samples.record_end,
                        run_end: samples.run_end};
                if (due_q.size() == 0)
                    report_miss("sample with none pending", '0, got);
                else
                begin
                    want = due_q.pop_front();
                    if (got.sample !== want.sample)
                        report_miss("sample value", want, got);
                    else if (got.record_end !== want.record_end)
                        report_miss("record_end flag", want, got);
                    else if (got.run_end !== want.run_end)
                        report_miss("run_end flag", want, got);
                end
            end
        end
        samples_due = due_q.size();
    end

endmodule

@@ test/steim_frame_difference_decoder_tb.sv @@
module steim_frame_difference_decoder_tb
    import sfdd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound: a few hundred words, four samples each, receiver idling
    // most of the time, plus the long hold-off.
    localparam int LIMIT_CYCLES  = 500_000;
    // Cycles to let a word that yields nothing clear the pipe.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic clk;
    logic rst_n;
    int   src_idle_pct = 34;
    int   snk_idle_pct = 77;
    bit   hold_sink    = 1'b0;
    int   cycle_count  = 0;
    int   mismatches;
    int   due;

    sfdd_word_if   words ();
    sfdd_sample_if samples ();
    sfdd_cfg_if    cfg ();

    steim_frame_difference_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words),
        .samples (samples),
        .cfg     (cfg)
    );

    sfdd_sample_checker sample_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .words          (words),
        .samples        (samples),
        .cfg            (cfg),
        .mismatch_count (mismatches),
        .samples_due    (due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: drop ready at random, and hold it low for the whole
    // hold-off stretch so the decoder backs up into its input.
    initial
    begin
        samples.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            samples.ready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: end the run if the handshakes never finish.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("steim_frame_difference_decoder_tb failed");
        $finish;
    end

    // Offer one word and hold it until the decoder takes it. Ready is sampled
    // on the falling edge so the check never races the rising-edge update.
    task automatic send_word(input logic [31:0] w, input logic restart);
        bit taken;
        while ($urandom_range(99) < src_idle_pct)
        begin
            words.valid <= 1'b0;
            @(posedge clk);
        end
        words.valid        <= 1'b1;
        words.code_word    <= w;
        words.record_start <= restart;
        do
        begin
            @(negedge clk);
            taken = words.ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Wait until every predicted sample is out, then let any word that yields
    // nothing drain from the pipe.
    task automatic wait_idle();
        words.valid <= 1'b0;
        @(posedge clk);
        while (due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(input logic [15:0] total);
        bit taken;
        cfg.valid <= 1'b1;
        cfg.data  <= total;
        do
        begin
            @(negedge clk);
            taken = cfg.ready;
            @(posedge clk);
        end while (!taken);
        cfg.valid <= 1'b0;
    endtask

    // Data words lean on the corners: sign bits, all ones, lane maxima.
    function automatic logic [31:0] pick_data();
        case ($urandom_range(11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8080_8080;
            5:       return 32'h7F7F_7F7F;
            6:       return 32'h2000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Headers: mostly mixed codes, sometimes one code across the frame.
    function automatic logic [31:0] pick_header();
        code_t c;
        if ($urandom_range(3) == 0)
        begin
            c = code_t'($urandom_range(3));
            return {16{c}};
        end
        return $urandom;
    endfunction

    // Send a record laid out as frames: header, start, last, then data.
    // Now and then raise record_start on a stray word to break the sequence.
    task automatic send_record(input int nwords, input bit restart);
        for (int i = 0; i < nwords; i++)
        begin
            logic [31:0] w;
            bit          rs;
            w  = (i % FRAME_WORDS == 0) ? pick_header() : pick_data();
            rs = (i == 0) ? restart : ($urandom_range(39) == 0);
            send_word(w, rs);
        end
    endtask

    function automatic logic [15:0] pick_total(input int slot);
        case (slot)
            0:       return 16'($urandom_range(1, 48));
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    initial
    begin
        words.valid        <= 1'b0;
        words.code_word    <= '0;
        words.record_start <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.data           <= '0;
        rst_n              <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset acts as a record start; the default total of one lets the
        // first data word through and finishes the record on it.
        send_word({16{CODE_RAW}}, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h0BAD_F00D, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        // Finished record: this word advances position but yields nothing.
        send_word(32'h7FFF_FFFF, 1'b0);

        wait_idle();
        write_total(16'hFFFF);
        // Every code, with a sum that wraps past the top of the signed range.
        send_word({CODE_RAW, CODE_DIFF8, CODE_DIFF16, CODE_DIFF30, CODE_DIFF8,
                   CODE_DIFF30, 20'h0}, 1'b1);
        send_word(32'h7FFF_FFF0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h807F_01FF, 1'b0);
        send_word(32'h8000_7FFF, 1'b0);
        send_word(32'h2000_0000, 1'b0);
        send_word(32'h7F7F_7F7F, 1'b0);
        send_word(32'h1FFF_FFFF, 1'b0);

        // First difference of a record adds to the start value.
        send_word({CODE_DIFF8, 30'h0}, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0102_0304, 1'b0);

        // Count runs out in the middle of a word: drop the fourth difference.
        wait_idle();
        write_total(16'd3);
        send_word({CODE_DIFF8, 30'h0}, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFF80_7F01, 1'b0);

        // Zero total: nothing comes out at all.
        wait_idle();
        write_total(16'd0);
        send_word({16{CODE_DIFF30}}, 1'b1);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h3FFF_FFFF, 1'b0);

        // Random records in three idling modes, three totals each. A record
        // may carry on across a new total without a restart, which also
        // covers lowering the total below the count already emitted.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 34;
                    snk_idle_pct = 77;
                end
                1:
                begin
                    src_idle_pct = 77;
                    snk_idle_pct = 34;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int slot = 0; slot < 3; slot++)
            begin
                int sent;
                int n;
                bit carry_on;
                wait_idle();
                write_total(pick_total(slot));
                carry_on = (slot > 0) && ($urandom_range(1) == 1);
                sent     = 0;
                while (sent < 10)
                begin
                    n = $urandom_range(4, 24);
                    send_record(n, !(carry_on && sent == 0));
                    sent += n;
                end
            end
        end

        // Back-pressure: stall the receiver for a long stretch while words
        // keep coming, so the decoder fills and stops taking input.
        wait_idle();
        write_total(16'hFFFF);
        fork
            begin
                hold_sink <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink <= 1'b0;
            end
        join_none
        send_record(40, 1'b1);

        wait_idle();
        if (mismatches == 0 && due == 0)
            $display("steim_frame_difference_decoder_tb passed");
        else
            $display("steim_frame_difference_decoder_tb failed");
        $finish;
    end

endmodule
